// ===== rtl/agc_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// agc_pkg: shared types and constants for the anagram group classifier
// Holds the sequencer state encoding, the input operation codes and the
// result status codes.
// ---------------------------------------------------------------------------
package agc_pkg;

  localparam logic FUNC_BYTE  = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_LONG = 2'd2;

  localparam int unsigned KEY_BYTE_W = 8;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned GID_W      = 6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_SEARCH,
    S_CHECK,
    S_UPDATE,
    S_OUT
  } agc_state_t;

endpackage
`default_nettype wire

// ===== rtl/agc_key_sorter.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// agc_key_sorter: insertion register for the canonical word key
// Holds the bytes of the current word in ascending order. A new byte is
// placed by one shift step per cycle, with one shared compare unit.
// ---------------------------------------------------------------------------
module agc_key_sorter
  import agc_pkg::*;
#(
  parameter int unsigned MAX_WORD_LEN = 8,
  parameter int unsigned LEN_W        = 4
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  clear,
  input  wire logic                                  start,
  input  wire logic [KEY_BYTE_W-1:0]                 byte_in,
  output logic                                       busy,
  output logic [LEN_W-1:0]                           key_len,
  output logic                                       too_long,
  output logic [MAX_WORD_LEN-1:0][KEY_BYTE_W-1:0]    key
);

  localparam int unsigned POS_W = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;

  logic [MAX_WORD_LEN-1:0][KEY_BYTE_W-1:0] key_r, key_nxt;
  logic [LEN_W-1:0]                        len_r, len_nxt;
  logic                                    long_r, long_nxt;
  logic                                    busy_r, busy_nxt;
  logic [LEN_W-1:0]                        pos_r, pos_nxt;
  logic [KEY_BYTE_W-1:0]                   b_r, b_nxt;
  logic [KEY_BYTE_W-1:0]                   left_byte;
  logic [POS_W-1:0]                        pos_idx, left_idx;

  assign pos_idx   = pos_r[POS_W-1:0];
  assign left_idx  = pos_idx - POS_W'(1);
  assign left_byte = key_r[left_idx];

  always_comb begin
    key_nxt  = key_r;
    len_nxt  = len_r;
    long_nxt = long_r;
    busy_nxt = busy_r;
    pos_nxt  = pos_r;
    b_nxt    = b_r;
    if (clear) begin
      key_nxt  = '0;
      len_nxt  = '0;
      long_nxt = 1'b0;
      busy_nxt = 1'b0;
    end else if (start) begin
      if (len_r >= LEN_W'(MAX_WORD_LEN)) begin
        long_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
        pos_nxt  = len_r;
        b_nxt    = byte_in;
      end
    end else if (busy_r) begin
      // Shift the larger neighbor right, or drop the byte into its slot.
      if (pos_r != '0 && left_byte > b_r) begin
        key_nxt[pos_idx] = left_byte;
        pos_nxt          = pos_r - LEN_W'(1);
      end else begin
        key_nxt[pos_idx] = b_r;
        len_nxt          = len_r + LEN_W'(1);
        busy_nxt         = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r  <= '0;
      len_r  <= '0;
      long_r <= 1'b0;
      busy_r <= 1'b0;
    end else begin
      key_r  <= key_nxt;
      len_r  <= len_nxt;
      long_r <= long_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    b_r   <= b_nxt;
  end

  assign busy     = busy_r;
  assign key_len  = len_r;
  assign too_long = long_r;
  assign key      = key_r;

endmodule
`default_nettype wire

// ===== rtl/anagram_group_classifier_core.sv =====
`default_nettype none
// Steps: a byte that does not end a word is shifted into the key, one step more for each
// larger byte it moves past, before the input is ready again; a byte dropped from an overlong
// word is not shifted in. A word end then adds a memory read and a key compare per group
// compared, a final search step when no group matches, an update step and an output state
// that holds until out_tready. One word at a time, in_tready low meanwhile.
// Reset clears the word state and the group count; no clearing pass.
// ---------------------------------------------------------------------------
// anagram_group_classifier_core: top level
// Sorts word bytes into a key, then searches and updates the group table.
// ---------------------------------------------------------------------------
module anagram_group_classifier_core
  import agc_pkg::*;
#(
  parameter int unsigned MAX_WORD_LEN = 8,
  parameter int unsigned MAX_GROUPS   = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // char_code
  input  wire logic        in_tuser,   // func
  input  wire logic        in_tlast,   // last_char
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // group_id[5:0], member_index[21:6], status[23:22]
  output logic             out_tuser   // new_group
);

  localparam int unsigned LEN_W = $clog2(MAX_WORD_LEN + 1);
  localparam int unsigned GI_W  = $clog2(MAX_GROUPS);
  localparam int unsigned GC_W  = $clog2(MAX_GROUPS + 1);
  localparam int unsigned KEY_W = MAX_WORD_LEN * KEY_BYTE_W;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  agc_state_t state_r, state_nxt;

  logic                                 acc, s_clear, s_start, s_busy, s_long;
  logic [LEN_W-1:0]                     s_len;
  logic [MAX_WORD_LEN-1:0][KEY_BYTE_W-1:0] s_key;
  logic                                 last_r;

  logic [KEY_W-1:0]   mem_key [MAX_GROUPS];
  logic [LEN_W-1:0]   mem_len [MAX_GROUPS];
  logic [COUNT_W-1:0] mem_cnt [MAX_GROUPS];
  logic [KEY_W-1:0]   rd_key_r;
  logic [LEN_W-1:0]   rd_len_r;
  logic [COUNT_W-1:0] rd_cnt_r;

  logic [GC_W-1:0]    used_r;
  logic [GC_W-1:0]    idx_r;
  logic               found_r;
  logic               wr_en;
  logic [GI_W-1:0]    wr_addr;
  logic [COUNT_W-1:0] wr_cnt;
  logic               wr_new;

  logic [GID_W-1:0]   o_gid_r;
  logic [COUNT_W-1:0] o_idx_r;
  logic               o_new_r;
  logic [1:0]         o_st_r;

  assign acc     = in_tvalid && in_tready;
  assign s_clear = acc && in_tuser == FUNC_CLEAR;
  assign s_start = acc && in_tuser == FUNC_BYTE;

  agc_key_sorter #(.MAX_WORD_LEN(MAX_WORD_LEN), .LEN_W(LEN_W)) u_sorter (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (s_clear || (state_r == S_OUT && out_tready)),
    .start    (s_start),
    .byte_in  (in_tdata),
    .busy     (s_busy),
    .key_len  (s_len),
    .too_long (s_long),
    .key      (s_key)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (s_start) state_nxt = S_INSERT;
      S_INSERT: if (!s_busy) begin
                  if (!last_r) state_nxt = S_IDLE;
                  else if (s_long) state_nxt = S_OUT;
                  else state_nxt = S_SEARCH;
                end
      S_SEARCH: state_nxt = (idx_r >= used_r) ? S_UPDATE : S_CHECK;
      S_CHECK:  state_nxt = (rd_len_r == s_len && rd_key_r == KEY_W'(s_key)) ?
                            S_UPDATE : S_SEARCH;
      S_UPDATE: state_nxt = S_OUT;
      S_OUT:    if (out_tready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_tready  = (state_r == S_IDLE);
    out_tvalid = (state_r == S_OUT);
    wr_en      = 1'b0;
    wr_new     = !found_r;
    wr_addr    = idx_r[GI_W-1:0];
    wr_cnt     = found_r ? ((rd_cnt_r == COUNT_MAX) ? rd_cnt_r : rd_cnt_r + 1'b1)
                         : COUNT_W'(1);
    case (state_r)
      S_UPDATE: wr_en = found_r || (used_r < GC_W'(MAX_GROUPS));
      default:  wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (s_clear) used_r <= '0;
      else if (wr_en && wr_new) used_r <= used_r + 1'b1;
    end
  end

  // Group table: one read or one write per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_cnt[wr_addr] <= wr_cnt;
      if (wr_new) begin
        mem_key[wr_addr] <= KEY_W'(s_key);
        mem_len[wr_addr] <= s_len;
      end
    end else if (state_r == S_SEARCH) begin
      rd_key_r <= mem_key[idx_r[GI_W-1:0]];
      rd_len_r <= mem_len[idx_r[GI_W-1:0]];
      rd_cnt_r <= mem_cnt[idx_r[GI_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (s_start) last_r <= in_tlast;
    case (state_r)
      S_INSERT: begin
        idx_r   <= '0;
        found_r <= 1'b0;
        o_gid_r <= '0;
        o_idx_r <= '0;
        o_new_r <= 1'b0;
        o_st_r  <= ST_LONG;
      end
      S_CHECK: begin
        if (rd_len_r == s_len && rd_key_r == KEY_W'(s_key)) found_r <= 1'b1;
        else idx_r <= idx_r + 1'b1;
      end
      S_UPDATE: begin
        if (found_r) begin
          o_gid_r <= GID_W'(idx_r);
          o_idx_r <= rd_cnt_r;
          o_new_r <= 1'b0;
          o_st_r  <= ST_OK;
        end else if (used_r < GC_W'(MAX_GROUPS)) begin
          o_gid_r <= GID_W'(used_r);
          o_idx_r <= '0;
          o_new_r <= 1'b1;
          o_st_r  <= ST_OK;
        end else begin
          o_gid_r <= '0;
          o_idx_r <= '0;
          o_new_r <= 1'b0;
          o_st_r  <= ST_FULL;
        end
      end
      default: ;
    endcase
  end

  assign out_tdata = {o_st_r, o_idx_r, o_gid_r};
  assign out_tuser = o_new_r;

endmodule
`default_nettype wire
